// File: rtl/assert_macros.svh
// assertion macros shared by the deque rtl
// depends on a clk and an active-low arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define DQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on the next edge outside reset
`define DQ_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

// File: rtl/dq_pkg.sv
// shared types and constants of the double-ended queue
// no dependencies; used by dq_ctrl, dq_dp and double_ended_queue
package dq_pkg;

	// default sizing
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// beat field widths
	localparam int CMD_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int DATA_OUT_W = 32;
	localparam int IN_W       = ((CMD_W + VALUE_W + 7) / 8) * 8;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic commit;
	} dq_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy;
		logic out_valid;
	} dq_sts_t;

endpackage

// File: rtl/dq_ctrl.sv
// controller of the double-ended queue: accepts a beat, then commits it
// depends on dq_pkg and assert_macros.svh
`include "assert_macros.svh"

module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output dq_pkg::dq_ctl_t ctl,
	input  dq_pkg::dq_sts_t sts
);

	dq_pkg::state_t state_q;
	dq_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		s_tready   = 1'b0;
		ctl.load   = 1'b0;
		ctl.commit = 1'b0;
		case (state_q)
			dq_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load  = 1'b1;
					state_nxt = dq_pkg::S_EXEC;
				end
			end
			dq_pkg::S_EXEC: begin
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					state_nxt  = dq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dq_pkg::S_IDLE;
			end
		endcase
	end

	// a loaded beat is always followed by the execute state
	`DQ_ASSERT_NEXT(a_load_exec, ctl.load, state_q == dq_pkg::S_EXEC, "load not followed by exec")
	// a commit always lands in a free result register
	`DQ_ASSERT_NEXT(a_commit_out, ctl.commit, sts.out_valid, "commit did not fill result register")

endmodule

// File: rtl/dq_dp.sv
// datapath of the double-ended queue: slot memory, ring pointers, result register
// depends on dq_pkg and assert_macros.svh
`include "assert_macros.svh"

module dq_dp #(
	parameter  int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter  int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
	localparam int PTR_W      = $clog2(DEPTH),
	localparam int CNT_W      = $clog2(DEPTH + 1),
	localparam int OUT_W      = ((dq_pkg::STATUS_W + dq_pkg::DATA_OUT_W + CNT_W + 1 + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [dq_pkg::IN_W-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_W-1:0]        m_tdata,
	input  dq_pkg::dq_ctl_t         ctl,
	output dq_pkg::dq_sts_t         sts
);

	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [PTR_W-1:0]          head_q;
	logic [CNT_W-1:0]          occ_q;
	dq_pkg::cmd_t              cmd_q;
	logic [DATA_WIDTH-1:0]     word_q;
	logic [DATA_WIDTH-1:0]     rd_q;
	logic                      out_valid_q;
	dq_pkg::status_t           status_q;
	logic [dq_pkg::DATA_OUT_W-1:0] data_q;
	logic [CNT_W-1:0]          count_q;
	logic                      empty_q;

	dq_pkg::cmd_t          cmd_in;
	logic [DATA_WIDTH-1:0] word_in;
	logic [SUM_W-1:0]      sum;
	logic [PTR_W-1:0]      tail;
	logic [PTR_W-1:0]      back;
	logic [PTR_W-1:0]      head_m1;
	logic [PTR_W-1:0]      head_p1;
	logic [PTR_W-1:0]      rd_addr;
	logic                  full;
	logic                  empty;
	logic                  is_push;
	logic [PTR_W-1:0]      head_nxt;
	logic [CNT_W-1:0]      occ_nxt;
	logic                  wr_en;
	logic [PTR_W-1:0]      wr_addr;
	dq_pkg::status_t       status_nxt;
	logic [DATA_WIDTH-1:0] data_nxt;

	// unpack the input beat
	assign cmd_in  = dq_pkg::cmd_t'(s_tdata[dq_pkg::CMD_W-1:0]);
	assign word_in = DATA_WIDTH'(s_tdata[dq_pkg::CMD_W +: dq_pkg::VALUE_W]);

	// ring positions around the head
	assign sum     = SUM_W'(head_q) + SUM_W'(occ_q);
	assign tail    = (sum >= DEPTH_S) ? PTR_W'(sum - DEPTH_S) : PTR_W'(sum);
	assign back    = (tail == '0) ? LAST_PTR : tail - 1'b1;
	assign head_m1 = (head_q == '0) ? LAST_PTR : head_q - 1'b1;
	assign head_p1 = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
	assign full    = (occ_q == DEPTH_C);
	assign empty   = (occ_q == '0);
	assign is_push = (cmd_q == dq_pkg::CMD_PUSH_FRONT) || (cmd_q == dq_pkg::CMD_PUSH_BACK);

	// read slot chosen when the beat is taken
	assign rd_addr = ((cmd_in == dq_pkg::CMD_POP_FRONT) || (cmd_in == dq_pkg::CMD_PEEK_FRONT))
		? head_q : back;

	// command execution
	always_comb begin
		head_nxt   = head_q;
		occ_nxt    = occ_q;
		wr_en      = 1'b0;
		wr_addr    = tail;
		status_nxt = dq_pkg::ST_OK;
		data_nxt   = '0;
		case (cmd_q)
			dq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_nxt = dq_pkg::ST_FULL;
				end else begin
					head_nxt = head_m1;
					wr_en    = 1'b1;
					wr_addr  = head_m1;
					occ_nxt  = occ_q + 1'b1;
				end
			end
			dq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = dq_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					occ_nxt = occ_q + 1'b1;
				end
			end
			dq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = dq_pkg::ST_EMPTY;
				end else begin
					data_nxt = rd_q;
					head_nxt = head_p1;
					occ_nxt  = occ_q - 1'b1;
				end
			end
			dq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = dq_pkg::ST_EMPTY;
				end else begin
					data_nxt = rd_q;
					occ_nxt  = occ_q - 1'b1;
				end
			end
			dq_pkg::CMD_PEEK_FRONT, dq_pkg::CMD_PEEK_BACK: begin
				if (empty) begin
					status_nxt = dq_pkg::ST_EMPTY;
				end else begin
					data_nxt = rd_q;
				end
			end
			default: begin
				status_nxt = dq_pkg::ST_OK;
			end
		endcase
	end

	// slot memory: write on commit, registered read on load
	always_ff @(posedge clk) begin
		if (ctl.commit && wr_en) begin
			mem[wr_addr] <= word_q;
		end
		if (ctl.load) begin
			rd_q <= mem[rd_addr];
		end
	end

	// captured command beat
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_in;
			word_q <= word_in;
		end
	end

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (ctl.commit) begin
			head_q <= head_nxt;
			occ_q  <= occ_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= status_nxt;
			data_q   <= dq_pkg::DATA_OUT_W'(data_nxt);
			count_q  <= occ_nxt;
			empty_q  <= (occ_nxt == '0);
		end
	end

	// output beat and status
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = OUT_W'({empty_q, count_q, data_q, status_q});
	assign sts.out_busy  = out_valid_q && !m_tready;
	assign sts.out_valid = out_valid_q;

	// occupancy never exceeds the ring size
	`DQ_ASSERT(a_occ_range, occ_q <= DEPTH_C, "occupancy above depth")
	// a refused push leaves the count alone
	`DQ_ASSERT_NEXT(a_full_hold, ctl.commit && is_push && full, $stable(occ_q), "full push changed count")
	// empty flag agrees with the reported count
	`DQ_ASSERT(a_empty_flag, !out_valid_q || (empty_q == (count_q == '0)), "empty flag mismatch")

endmodule

// File: rtl/double_ended_queue.sv
// top level of the double-ended queue: controller plus datapath
// depends on dq_pkg, dq_ctrl and dq_dp
//
// Each command beat runs in two steps: the registered read of the front or
// back slot when the beat is taken, then the update of the ring pointers,
// the write of a pushed word and the load of the result register. A new beat
// waits for the last one's commit. The result register decouples the two
// sides: the next beat is taken while a result still waits, and execution
// holds only when that register is still occupied. Push on a full queue
// returns status full, pop or peek on an empty queue returns status empty,
// both with data zero and no change to the store. Codes 6 and 7 are no-ops.
// Slots need no clearing after reset; only data of written slots reaches a result.
module double_ended_queue #(
	parameter  int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter  int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
	localparam int CNT_W      = $clog2(DEPTH + 1),
	localparam int OUT_W      = ((dq_pkg::STATUS_W + dq_pkg::DATA_OUT_W + CNT_W + 1 + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [dq_pkg::IN_W-1:0] s_tdata,   // cmd, value
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_W-1:0]        m_tdata    // status, data_out, entry_count, is_empty
);

	dq_pkg::dq_ctl_t ctl;
	dq_pkg::dq_sts_t sts;

	// sequencing
	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// storage and result
	dq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.ctl      (ctl),
		.sts      (sts)
	);

endmodule
